// ===== rtl/fdf_pkg.sv =====
// Shared types and constants for the flood duplicate filter.
// No dependencies; used by fdf_front, fdf_back, the top level and fdf_checker.
package fdf_pkg;

    localparam int unsigned ADDR_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned NUM_W  = 32;
    localparam int unsigned HOP_W  = 8;
    localparam logic [HOP_W-1:0] HOP_MAX = 8'd255;

    // action codes
    localparam logic ACT_RECEIVED = 1'b0;
    localparam logic ACT_LOCAL    = 1'b1;

    // one classified header as it waits in the queue
    typedef struct packed {
        logic              is_local;
        logic [ADDR_W-1:0] addr;
        logic [NUM_W-1:0]  num;
        logic [HOP_W-1:0]  hops;
        logic [HOP_W-1:0]  hops_inc;
    } t_item;

    // queue to back end handshake
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

endpackage

// ===== rtl/fdf_front.sv =====
// Front end: accepts headers, classifies them and holds them in a two-entry queue.
// Depends on fdf_pkg.
module fdf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_action,
    input  logic [fdf_pkg::HALF_W-1:0] i_source_address_upper,
    input  logic [fdf_pkg::HALF_W-1:0] i_source_address_lower,
    input  logic [fdf_pkg::NUM_W-1:0]  i_message_number,
    input  logic [fdf_pkg::HOP_W-1:0]  i_hop_count,
    output fdf_pkg::t_queue_out       o_queue,
    input  logic                      i_pop
);

    fdf_pkg::t_item r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    fdf_pkg::t_item w_item;
    logic           w_push;
    logic           w_pop;

    // classify the incoming header
    always_comb begin
        w_item.is_local = (i_action == fdf_pkg::ACT_LOCAL);
        w_item.addr     = {i_source_address_upper, i_source_address_lower};
        w_item.num      = i_message_number;
        w_item.hops     = i_hop_count;
        w_item.hops_inc = (i_hop_count == fdf_pkg::HOP_MAX) ? fdf_pkg::HOP_MAX
                                                            : i_hop_count + 1'b1;
    end

    assign o_ready       = (r_count != 2'd2);
    assign w_push        = i_valid && o_ready;
    assign w_pop         = i_pop && (r_count != 2'd0);
    assign o_queue.valid = (r_count != 2'd0);
    assign o_queue.item  = r_slot[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_item;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/fdf_back.sv =====
// Back end: searches the ring memory one slot a cycle, records new pairs and
// holds the result in an output register. Depends on fdf_pkg.
module fdf_back #(
    parameter int unsigned RING_ENTRIES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  fdf_pkg::t_queue_out      i_queue,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_forward,
    output logic                     o_duplicate,
    output logic [fdf_pkg::HOP_W-1:0] o_hops_out
);

    localparam int unsigned IDX_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(RING_ENTRIES - 1);
    localparam int unsigned ENT_W = fdf_pkg::ADDR_W + fdf_pkg::NUM_W;

    fdf_pkg::t_state r_state, n_state;
    fdf_pkg::t_item  r_item;
    logic [ENT_W-1:0] r_mem [RING_ENTRIES];
    logic [ENT_W-1:0] r_rd_data;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_cmp_slot;
    logic             r_cmp_vld;
    logic             r_issued_all;
    logic             r_dup;
    logic [IDX_W-1:0] r_wslot;
    logic             r_full;
    logic             r_out_valid;
    logic             r_out_forward;
    logic             r_out_dup;
    logic [fdf_pkg::HOP_W-1:0] r_out_hops;

    logic             w_rd_en;
    logic             w_wr_en;
    logic             w_load_out;
    logic             w_start;
    logic             w_slot_valid;
    logic             w_hit;
    logic             w_set_dup;
    logic             w_out_free;
    logic [IDX_W-1:0] w_next_slot;

    // slots 1..write pointer are filled until the ring wraps, then all are
    assign w_slot_valid = r_full || ((r_cmp_slot != '0) && (r_cmp_slot <= r_wslot));
    assign w_hit        = r_cmp_vld && w_slot_valid
                          && (r_rd_data == {r_item.addr, r_item.num});
    assign w_out_free   = !r_out_valid || i_ready;
    assign w_next_slot  = (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;

    // next state and control
    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        w_start    = 1'b0;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_load_out = 1'b0;
        w_set_dup  = 1'b0;
        case (r_state)
            fdf_pkg::S_IDLE: begin
                if (i_queue.valid) begin
                    o_pop   = 1'b1;
                    w_start = 1'b1;
                    n_state = i_queue.item.is_local ? fdf_pkg::S_DONE : fdf_pkg::S_SEARCH;
                end
            end
            fdf_pkg::S_SEARCH: begin
                w_rd_en = !r_issued_all;
                if (w_hit) begin
                    w_set_dup = 1'b1;
                    n_state   = fdf_pkg::S_DONE;
                end else if (r_cmp_vld && (r_cmp_slot == LAST_SLOT)) begin
                    n_state = fdf_pkg::S_DONE;
                end
            end
            fdf_pkg::S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    w_wr_en    = !r_dup;
                    n_state    = fdf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fdf_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fdf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_next_slot] <= {r_item.addr, r_item.num};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // current item and search walk
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_item <= i_queue.item;
        end
        if (w_start) begin
            r_idx      <= '0;
            r_cmp_slot <= '0;
        end else if (w_rd_en) begin
            r_idx      <= r_idx + 1'b1;
            r_cmp_slot <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld    <= 1'b0;
            r_issued_all <= 1'b0;
            r_dup        <= 1'b0;
        end else if (w_start) begin
            r_cmp_vld    <= 1'b0;
            r_issued_all <= 1'b0;
            r_dup        <= 1'b0;
        end else begin
            r_cmp_vld <= w_rd_en;
            if (w_rd_en && (r_idx == LAST_SLOT)) begin
                r_issued_all <= 1'b1;
            end
            if (w_set_dup) begin
                r_dup <= 1'b1;
            end
        end
    end

    // ring write pointer and wrap flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_full  <= 1'b0;
        end else if (w_wr_en) begin
            r_wslot <= w_next_slot;
            if (w_next_slot == '0) begin
                r_full <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_forward <= !r_dup;
            r_out_dup     <= r_dup;
            r_out_hops    <= r_dup ? r_item.hops : r_item.hops_inc;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_forward   = r_out_forward;
    assign o_duplicate = r_out_dup;
    assign o_hops_out  = r_out_hops;

endmodule

// ===== rtl/flood_duplicate_filter.sv =====
// Top level of the flood duplicate filter.
// Instantiates fdf_front and fdf_back; depends on fdf_pkg.
//
// In the back end, a received header is searched against the ring memory, which
// has one read port and is searched one slot per cycle, stopping early on a
// match. A locally originated header skips the search. A two-entry queue in
// front keeps accepting headers during a search until both entries are full,
// and an output register holds each result until it is taken, so the sustained
// rate is set by the search loop. The ring contents need no clearing pass; slot
// validity follows from the write pointer and a wrap flag.
module flood_duplicate_filter #(
    parameter int unsigned RING_ENTRIES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic [fdf_pkg::HALF_W-1:0] i_source_address_upper,
    input  logic [fdf_pkg::HALF_W-1:0] i_source_address_lower,
    input  logic [fdf_pkg::NUM_W-1:0]  i_message_number,
    input  logic [fdf_pkg::HOP_W-1:0]  i_hop_count,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_forward,
    output logic                       o_duplicate,
    output logic [fdf_pkg::HOP_W-1:0]  o_hops_out
);

    fdf_pkg::t_queue_out w_queue;
    logic                w_pop;

    // accept and classify
    fdf_front u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_action               (i_action),
        .i_source_address_upper (i_source_address_upper),
        .i_source_address_lower (i_source_address_lower),
        .i_message_number       (i_message_number),
        .i_hop_count            (i_hop_count),
        .o_queue                (w_queue),
        .i_pop                  (w_pop)
    );

    // search, record and report
    fdf_back #(
        .RING_ENTRIES (RING_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_queue     (w_queue),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_forward   (o_forward),
        .o_duplicate (o_duplicate),
        .o_hops_out  (o_hops_out)
    );

endmodule

// ===== rtl/fdf_checker.sv =====
// Port-level checks for flood_duplicate_filter, attached with a bind.
// Depends on fdf_pkg.
module fdf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic                       o_forward,
    input logic                       o_duplicate,
    input logic [fdf_pkg::HOP_W-1:0]  o_hops_out
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable({o_forward, o_duplicate, o_hops_out}))
        else $error("result changed while stalled");

    // each result either forwards or is a duplicate, never both
    a_one_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_forward != o_duplicate))
        else $error("forward and duplicate disagree");

    // a forwarded hop count is incremented with saturation, so never zero
    a_hops_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_forward |-> (o_hops_out != '0))
        else $error("forwarded hop count is zero");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind flood_duplicate_filter fdf_checker u_fdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_forward   (o_forward),
    .o_duplicate (o_duplicate),
    .o_hops_out  (o_hops_out)
);
